// ===== sv/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared constants, types and helper functions of the head/tail deframer.
// ----------------------------------------------------------------------------
package htfd_pkg;

   // Longest tail sequence that can be matched, in bytes.
   localparam int MAX_TAIL = 4;
   // Width of the frame byte counter.
   localparam int COUNT_BITS = 8;
   // Entries of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   localparam int SEEN_BITS = MAX_TAIL * 8;
   localparam int WINDOW_BITS = (MAX_TAIL - 1) * 8;
   localparam int TLEN_BITS = $clog2(MAX_TAIL + 1);
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Register map, as word indexes.
   localparam logic [1:0] REG_HEAD_BYTE    = 2'd0;
   localparam logic [1:0] REG_TAIL_PATTERN = 2'd1;
   localparam logic [1:0] REG_TAIL_LENGTH  = 2'd2;

   localparam logic [7:0]  HEAD_BYTE_RESET    = 8'hAA;
   localparam logic [31:0] TAIL_PATTERN_RESET = 32'hCC33C33C;
   localparam logic [2:0]  TAIL_LENGTH_RESET  = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_DISCARD    = 2'd0;
   localparam logic [1:0] ST_HEAD       = 2'd1;
   localparam logic [1:0] ST_FRAME_BYTE = 2'd2;
   localparam logic [1:0] ST_FRAME_END  = 2'd3;

   typedef struct packed {
      logic [7:0]           head_byte;
      logic [31:0]          tail_pattern;
      logic [TLEN_BITS-1:0] tail_len;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       head_hit;
      logic       tail_hit;
   } entry_type;

   // Clamps the programmed tail length into 1..MAX_TAIL.
   function automatic logic [TLEN_BITS-1:0] clamp_tlen(input logic [2:0] raw);
      logic [TLEN_BITS-1:0] res;
      if (raw == 3'd0) begin
         res = TLEN_BITS'(1);
      end else if (32'(raw) > 32'(MAX_TAIL)) begin
         res = TLEN_BITS'(MAX_TAIL);
      end else begin
         res = TLEN_BITS'(raw);
      end
      return res;
   endfunction

   // Byte mask covering the newest tlen bytes of the compare word.
   function automatic logic [SEEN_BITS-1:0] tail_mask(input logic [TLEN_BITS-1:0] tlen);
      logic [SEEN_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < MAX_TAIL; i++) begin
         if (i < int'(tlen)) begin
            m[i*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   function automatic logic [7:0] cap_byte(input logic [COUNT_BITS-1:0] v);
      logic [7:0] res;
      if (32'(v) > 32'd255) begin
         res = 8'hFF;
      end else begin
         res = 8'(v);
      end
      return res;
   endfunction

endpackage

// ===== sv/htfd_req_if.sv =====
// ----------------------------------------------------------------------------
// htfd_req_if
// Request channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
interface htfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/htfd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// htfd_rsp_if
// Result channel carrying the classification of one received byte.
// ----------------------------------------------------------------------------
interface htfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [7:0] frame_length;
   logic       length_saturated;

   modport source (output valid, output status, output data_byte, output byte_index,
                   output frame_length, output length_saturated, input ready);
   modport sink (input valid, input status, input data_byte, input byte_index,
                 input frame_length, input length_saturated, output ready);
endinterface

// ===== sv/htfd_csr.sv =====
// ----------------------------------------------------------------------------
// htfd_csr
// APB register file holding the head byte and the tail sequence settings.
// ----------------------------------------------------------------------------
module htfd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [htfd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output htfd_pkg::cfg_type              cfg
);

   logic [7:0]  head_byte_ff;
   logic [31:0] tail_pattern_ff;
   logic [2:0]  tail_length_ff;
   logic [1:0]  reg_index;
   logic        wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff    <= htfd_pkg::HEAD_BYTE_RESET;
         tail_pattern_ff <= htfd_pkg::TAIL_PATTERN_RESET;
         tail_length_ff  <= htfd_pkg::TAIL_LENGTH_RESET;
      end else if (wr_en) begin
         case (reg_index)
            htfd_pkg::REG_HEAD_BYTE: begin
               head_byte_ff <= pwdata[7:0];
            end
            htfd_pkg::REG_TAIL_PATTERN: begin
               tail_pattern_ff <= pwdata;
            end
            htfd_pkg::REG_TAIL_LENGTH: begin
               tail_length_ff <= pwdata[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         htfd_pkg::REG_HEAD_BYTE:    prdata = {24'd0, head_byte_ff};
         htfd_pkg::REG_TAIL_PATTERN: prdata = tail_pattern_ff;
         htfd_pkg::REG_TAIL_LENGTH:  prdata = {29'd0, tail_length_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg.head_byte    = head_byte_ff;
   assign cfg.tail_pattern = tail_pattern_ff;
   assign cfg.tail_len     = htfd_pkg::clamp_tlen(tail_length_ff);

endmodule

// ===== sv/htfd_front.sv =====
// ----------------------------------------------------------------------------
// htfd_front
// Accepts bytes and tags each one with head and tail compare results.
// ----------------------------------------------------------------------------
module htfd_front (
   input  logic                 clock,
   input  logic                 reset,
   htfd_req_if.sink             req,
   input  htfd_pkg::cfg_type    cfg,
   input  logic                 push_ready,
   output logic                 push_valid,
   output htfd_pkg::entry_type  push_entry
);

   logic [htfd_pkg::WINDOW_BITS-1:0] window_ff;
   logic [htfd_pkg::WINDOW_BITS-1:0] window_in;
   logic [htfd_pkg::SEEN_BITS-1:0]   seen;
   logic [htfd_pkg::SEEN_BITS-1:0]   mask;
   logic [htfd_pkg::SEEN_BITS-1:0]   pattern;
   logic                             accept;

   // The window keeps the raw byte history. The back only trusts a tail hit
   // once at least tail_len bytes followed the head, and then every byte in
   // the compared span belongs to the current frame.
   assign seen    = {window_ff, req.rx_byte};
   assign mask    = htfd_pkg::tail_mask(cfg.tail_len);
   assign pattern = htfd_pkg::SEEN_BITS'(cfg.tail_pattern);

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign push_valid = req.valid;

   assign push_entry.rx_byte  = req.rx_byte;
   assign push_entry.head_hit = (req.rx_byte == cfg.head_byte);
   assign push_entry.tail_hit = ((seen & mask) == (pattern & mask));

   assign window_in = seen[htfd_pkg::WINDOW_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

// ===== sv/htfd_fifo.sv =====
// ----------------------------------------------------------------------------
// htfd_fifo
// Short queue of tagged bytes between the front and the back.
// ----------------------------------------------------------------------------
module htfd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  htfd_pkg::entry_type push_entry,
   output logic                push_ready,
   output logic                pop_valid,
   output htfd_pkg::entry_type pop_entry,
   input  logic                pop_ready
);

   htfd_pkg::entry_type              entries_ff [htfd_pkg::QUEUE_DEPTH];
   logic [htfd_pkg::QPTR_BITS-1:0]   wr_ptr_ff;
   logic [htfd_pkg::QPTR_BITS-1:0]   wr_ptr_in;
   logic [htfd_pkg::QPTR_BITS-1:0]   rd_ptr_ff;
   logic [htfd_pkg::QPTR_BITS-1:0]   rd_ptr_in;
   logic [htfd_pkg::QCNT_BITS-1:0]   count_ff;
   logic [htfd_pkg::QCNT_BITS-1:0]   count_in;
   logic                             do_push;
   logic                             do_pop;

   localparam logic [htfd_pkg::QPTR_BITS-1:0] LAST_PTR =
      htfd_pkg::QPTR_BITS'(htfd_pkg::QUEUE_DEPTH - 1);
   localparam logic [htfd_pkg::QCNT_BITS-1:0] FULL_COUNT =
      htfd_pkg::QCNT_BITS'(htfd_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/htfd_back.sv =====
// ----------------------------------------------------------------------------
// htfd_back
// Frame state tracking, byte counting and the registered result stage.
// ----------------------------------------------------------------------------
module htfd_back (
   input  logic                clock,
   input  logic                reset,
   input  htfd_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   input  htfd_pkg::entry_type pop_entry,
   output logic                pop_ready,
   htfd_rsp_if.source          rsp
);

   logic                              in_frame_ff;
   logic                              in_frame_in;
   logic [htfd_pkg::COUNT_BITS-1:0]   count_ff;
   logic [htfd_pkg::COUNT_BITS-1:0]   count_in;
   logic                              sat_ff;
   logic                              sat_in;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [1:0]                        status_ff;
   logic [1:0]                        status_in;
   logic [7:0]                        data_ff;
   logic [7:0]                        data_in;
   logic [7:0]                        index_ff;
   logic [7:0]                        index_in;
   logic [7:0]                        length_ff;
   logic [7:0]                        length_in;
   logic                              lsat_ff;
   logic                              lsat_in;
   logic [htfd_pkg::COUNT_BITS-1:0]   total;
   logic [htfd_pkg::COUNT_BITS-1:0]   tlen_wide;
   logic                              sat_next;
   logic                              end_hit;
   logic                              take;

   assign pop_ready = !out_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;

   assign tlen_wide = htfd_pkg::COUNT_BITS'(cfg.tail_len);
   assign total     = (count_ff < htfd_pkg::COUNT_MAX) ? count_ff + 1'b1 : htfd_pkg::COUNT_MAX;
   assign sat_next  = sat_ff || (total == htfd_pkg::COUNT_MAX);
   assign end_hit   = pop_entry.tail_hit && (total >= tlen_wide);

   always_comb begin
      in_frame_in  = in_frame_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      status_in    = status_ff;
      data_in      = data_ff;
      index_in     = index_ff;
      length_in    = length_ff;
      lsat_in      = lsat_ff;
      if (take) begin
         out_valid_in = 1'b1;
         data_in      = 8'd0;
         index_in     = 8'd0;
         length_in    = 8'd0;
         lsat_in      = 1'b0;
         if (!in_frame_ff) begin
            status_in = htfd_pkg::ST_DISCARD;
            if (pop_entry.head_hit) begin
               status_in   = htfd_pkg::ST_HEAD;
               in_frame_in = 1'b1;
               count_in    = '0;
               sat_in      = 1'b0;
            end
         end else begin
            data_in  = pop_entry.rx_byte;
            index_in = htfd_pkg::cap_byte(count_ff);
            lsat_in  = sat_next;
            if (end_hit) begin
               status_in   = htfd_pkg::ST_FRAME_END;
               length_in   = htfd_pkg::cap_byte(total - tlen_wide);
               in_frame_in = 1'b0;
               count_in    = '0;
               sat_in      = 1'b0;
            end else begin
               status_in = htfd_pkg::ST_FRAME_BYTE;
               count_in  = total;
               sat_in    = sat_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      index_ff  <= index_in;
      length_ff <= length_in;
      lsat_ff   <= lsat_in;
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.status           = status_ff;
   assign rsp.data_byte        = data_ff;
   assign rsp.byte_index       = index_ff;
   assign rsp.frame_length     = length_ff;
   assign rsp.length_saturated = lsat_ff;

endmodule

// ===== sv/head_tail_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// head_tail_frame_deframer
// Bytes pass the queue and result register; one per cycle while rsp is ready.
// The front compares each byte against head and tail, the back tracks the frame.
// Synchronous reset returns to hunting and restores the register defaults.
// ----------------------------------------------------------------------------
module head_tail_frame_deframer (
   input  logic                           clock,
   input  logic                           reset,
   htfd_req_if.sink                       req_chan,
   htfd_rsp_if.source                     rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [htfd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   htfd_pkg::cfg_type   cfg;
   htfd_pkg::entry_type push_entry;
   htfd_pkg::entry_type pop_entry;
   logic                push_valid;
   logic                push_ready;
   logic                pop_valid;
   logic                pop_ready;

   htfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   htfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   htfd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   htfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule

// ===== tb/tb_head_tail_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_head_tail_frame_deframer
// Self-checking bench for the head/tail frame deframer. A short directed table
// covers frame boundaries, a head byte inside a frame, short frames and tail
// lengths outside the legal range. Random frames follow under several register
// settings. Fixed rows carry their result; others use a cycle-free framer model.
// ----------------------------------------------------------------------------
module tb_head_tail_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT        = 27;
   localparam int LATENCY_SLACK   = 6;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_BYTES     = 180;
   localparam int DIRECTED_ROWS   = 31;
   localparam logic [1:0] REG_BEYOND_MAP = 2'd3;
   localparam logic [2:0] TLEN_PLAN [RANDOM_PHASES] =
      '{3'd4, 3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_length;
      logic       length_saturated;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]       rx;
      logic             fixed;
      frame_result_type result;
   } rx_item_type;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [1:0]       reg_idx;
      logic [31:0]      value;
      logic [7:0]       rx;
      logic             fixed;
      frame_result_type result;
   } dir_row_type;

   localparam frame_result_type NO_RESULT = '0;

   logic                           clock;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [htfd_pkg::ADDR_BITS-1:0] csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   htfd_req_if req_if ();
   htfd_rsp_if rsp_if ();

   head_tail_frame_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready)
   );

   // Register shadow and framer state of the model.
   logic [7:0]                       cfg_head;
   logic [31:0]                      cfg_pattern;
   logic [2:0]                       cfg_tlen;
   logic                             in_frame;
   logic [htfd_pkg::COUNT_BITS-1:0]  frame_count;
   logic [htfd_pkg::WINDOW_BITS-1:0] recent_window;
   logic                             count_saturated;

   rx_item_type      rx_stream [$];
   frame_result_type expected_results [$];
   rx_item_type      offered;
   int               error_count;
   int               quiet_cycles;
   int               rx_stall_left;
   bit               no_idle;

   dir_row_type directed [DIRECTED_ROWS] = '{
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h00, 1'b1,
        '{htfd_pkg::ST_DISCARD, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hAA, 1'b1,
        '{htfd_pkg::ST_HEAD, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hCC, 1'b1,
        '{htfd_pkg::ST_FRAME_BYTE, 8'hCC, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h33, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hC3, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h3C, 1'b1,
        '{htfd_pkg::ST_FRAME_END, 8'h3C, 8'h03, 8'h00, 1'b0}},
      // A head value inside a frame is plain payload.
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hAA, 1'b1,
        '{htfd_pkg::ST_HEAD, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hAA, 1'b1,
        '{htfd_pkg::ST_FRAME_BYTE, 8'hAA, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hCC, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h33, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hC3, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h3C, 1'b1,
        '{htfd_pkg::ST_FRAME_END, 8'h3C, 8'h04, 8'h01, 1'b0}},
      // An all-zero tail must not match before enough bytes have followed the head.
      '{ROW_WRITE, htfd_pkg::REG_TAIL_PATTERN, 32'h0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, REG_BEYOND_MAP, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h00, 1'b1,
        '{htfd_pkg::ST_FRAME_BYTE, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h00, 1'b1,
        '{htfd_pkg::ST_FRAME_END, 8'h00, 8'h03, 8'h00, 1'b0}},
      '{ROW_WRITE, htfd_pkg::REG_TAIL_LENGTH, 32'h0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'h00, 1'b1,
        '{htfd_pkg::ST_FRAME_END, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_WRITE, htfd_pkg::REG_HEAD_BYTE, 32'hFF, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, htfd_pkg::REG_TAIL_PATTERN, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, htfd_pkg::REG_TAIL_LENGTH, 32'h7, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hAA, 1'b1,
        '{htfd_pkg::ST_DISCARD, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hFF, 1'b1,
        '{htfd_pkg::ST_HEAD, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, htfd_pkg::REG_HEAD_BYTE, 32'h0, 8'hFF, 1'b1,
        '{htfd_pkg::ST_FRAME_END, 8'hFF, 8'h03, 8'h00, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int effective_tail_len();
      if (cfg_tlen == 3'd0) begin
         return 1;
      end
      return (int'(cfg_tlen) > htfd_pkg::MAX_TAIL) ? htfd_pkg::MAX_TAIL : int'(cfg_tlen);
   endfunction

   function automatic logic [7:0] clip_byte(input int unsigned v);
      return (v > 255) ? 8'hFF : 8'(v);
   endfunction

   // Advances the framer by one received byte and returns its classification.
   function automatic frame_result_type deframe_byte(input logic [7:0] rx);
      frame_result_type               res;
      int unsigned                    tlen;
      int unsigned                    total;
      int unsigned                    count_top;
      logic [htfd_pkg::SEEN_BITS-1:0] seen;
      logic [htfd_pkg::SEEN_BITS-1:0] mask;
      res = '0;
      if (!in_frame) begin
         if (rx == cfg_head) begin
            in_frame        = 1'b1;
            frame_count     = '0;
            recent_window   = '0;
            count_saturated = 1'b0;
            res.status      = htfd_pkg::ST_HEAD;
         end else begin
            res.status = htfd_pkg::ST_DISCARD;
         end
         return res;
      end
      tlen      = effective_tail_len();
      count_top = (1 << htfd_pkg::COUNT_BITS) - 1;
      total     = (int'(frame_count) < count_top) ? int'(frame_count) + 1 : count_top;
      if (total >= count_top) begin
         count_saturated = 1'b1;
      end
      seen = {recent_window, rx};
      mask = {htfd_pkg::SEEN_BITS{1'b1}} >> (htfd_pkg::SEEN_BITS - 8 * tlen);
      res.data_byte        = rx;
      res.byte_index       = clip_byte(frame_count);
      res.length_saturated = count_saturated;
      if (total >= tlen &&
          (seen & mask) == (htfd_pkg::SEEN_BITS'(cfg_pattern) & mask)) begin
         res.status       = htfd_pkg::ST_FRAME_END;
         res.frame_length = clip_byte(total - tlen);
         in_frame         = 1'b0;
         frame_count      = '0;
         recent_window    = '0;
         count_saturated  = 1'b0;
      end else begin
         res.status    = htfd_pkg::ST_FRAME_BYTE;
         frame_count   = htfd_pkg::COUNT_BITS'(total);
         recent_window = seen[htfd_pkg::WINDOW_BITS-1:0];
      end
      return res;
   endfunction

   function automatic void send_byte(input logic [7:0] rx);
      rx_stream.push_back('{rx: rx, fixed: 1'b0, result: NO_RESULT});
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Sender: one request per handshake, held until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (offered.fixed) begin
               void'(deframe_byte(offered.rx));
               expected_results.push_back(offered.result);
            end else begin
               expected_results.push_back(deframe_byte(offered.rx));
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (rx_stream.size() != 0 && (no_idle || $urandom_range(99, 0) >= IDLE_PCT)) begin
               offered = rx_stream.pop_front();
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= offered.rx;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result and throttles ready.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no request pending: status %0d, data_byte 0x%0h",
                   rsp_if.status, rsp_if.data_byte);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_if.status));
            compare_field("data_byte", 32'(want.data_byte), 32'(rsp_if.data_byte));
            compare_field("byte_index", 32'(want.byte_index), 32'(rsp_if.byte_index));
            compare_field("frame_length", 32'(want.frame_length), 32'(rsp_if.frame_length));
            compare_field("length_saturated", 32'(want.length_saturated),
                          32'(rsp_if.length_saturated));
         end
      end
      if (rx_stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         rx_stall_left--;
      end else begin
         rsp_if.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic apb_access(input logic [1:0] idx, input logic write,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= htfd_pkg::ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes one register, then reads all of them back against the shadow.
   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      apb_access(idx, 1'b1, value, rd);
      case (idx)
         htfd_pkg::REG_HEAD_BYTE:    cfg_head    = value[7:0];
         htfd_pkg::REG_TAIL_PATTERN: cfg_pattern = value;
         htfd_pkg::REG_TAIL_LENGTH:  cfg_tlen    = value[2:0];
         default: ;
      endcase
      apb_access(htfd_pkg::REG_HEAD_BYTE, 1'b0, 32'h0, rd);
      compare_field("head_byte readback", 32'(cfg_head), rd);
      apb_access(htfd_pkg::REG_TAIL_PATTERN, 1'b0, 32'h0, rd);
      compare_field("tail_pattern readback", cfg_pattern, rd);
      apb_access(htfd_pkg::REG_TAIL_LENGTH, 1'b0, 32'h0, rd);
      compare_field("tail_length readback", 32'(cfg_tlen), rd);
   endtask

   // Sender pause: sample at the falling edge so all updates of the cycle have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (rx_stream.size() != 0 || req_if.valid || expected_results.size() != 0);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   // Mostly well-formed frames, with some line noise and some frames whose
   // tail is cut one byte short so that they run on into the next frame.
   task automatic queue_frames(input int n_bytes, input bit long_first);
      int sent;
      int pick;
      int plen;
      int tlen;
      int tail_cnt;
      bit long_next;
      sent      = 0;
      long_next = long_first;
      tlen      = effective_tail_len();
      while (sent < n_bytes) begin
         pick = $urandom_range(99, 0);
         if (pick < 10) begin
            repeat ($urandom_range(4, 1)) begin
               send_byte(8'($urandom));
               sent++;
            end
         end else begin
            send_byte(cfg_head);
            sent++;
            plen = long_next ? $urandom_range(300, 250) : $urandom_range(24, 0);
            long_next = 1'b0;
            repeat (plen) begin
               send_byte(8'($urandom));
               sent++;
            end
            tail_cnt = (pick < 18) ? tlen - 1 : tlen;
            for (int k = 0; k < tail_cnt; k++) begin
               send_byte(cfg_pattern[8 * (tlen - 1 - k) +: 8]);
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [7:0]  head_sel;
      logic [31:0] pattern_sel;
      logic [2:0]  tlen_sel;
      reset           = 1'b1;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_if.valid    = 1'b0;
      req_if.rx_byte  = '0;
      rsp_if.ready    = 1'b0;
      cfg_head        = htfd_pkg::HEAD_BYTE_RESET;
      cfg_pattern     = htfd_pkg::TAIL_PATTERN_RESET;
      cfg_tlen        = htfd_pkg::TAIL_LENGTH_RESET;
      in_frame        = 1'b0;
      frame_count     = '0;
      recent_window   = '0;
      count_saturated = 1'b0;
      error_count     = 0;
      quiet_cycles    = 0;
      rx_stall_left   = 0;
      no_idle         = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE) begin
            wait_drained();
            set_register(directed[i].reg_idx, directed[i].value);
         end else begin
            rx_stream.push_back('{rx: directed[i].rx, fixed: directed[i].fixed,
                                  result: directed[i].result});
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         head_sel    = 8'($urandom);
         pattern_sel = $urandom;
         tlen_sel    = (p == RANDOM_PHASES - 1) ? 3'($urandom_range(7, 0)) : TLEN_PLAN[p];
         if (p == 1) begin
            head_sel    = 8'h00;
            pattern_sel = 32'h0;
         end else if (p == 2) begin
            head_sel    = 8'hFF;
            pattern_sel = 32'hFFFF_FFFF;
         end else if (p == 5) begin
            pattern_sel = {head_sel, 8'($urandom), head_sel, head_sel};
         end
         wait_drained();
         set_register(htfd_pkg::REG_HEAD_BYTE, {24'($urandom), head_sel});
         set_register(htfd_pkg::REG_TAIL_PATTERN, pattern_sel);
         set_register(htfd_pkg::REG_TAIL_LENGTH, {29'($urandom), tlen_sel});
         no_idle = (p == 3);
         // Hold the result side off long enough for the block to back up.
         if (p == 4) begin
            rx_stall_left = 300;
         end
         queue_frames(PHASE_BYTES, p == 0 || p == 5);
      end

      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/htfd_pkg.sv
sv/htfd_req_if.sv
sv/htfd_rsp_if.sv
sv/htfd_csr.sv
sv/htfd_front.sv
sv/htfd_fifo.sv
sv/htfd_back.sv
sv/head_tail_frame_deframer.sv
tb/tb_head_tail_frame_deframer.sv
